// ----- rtl/frame_element_local_stiffness_unit_macros.svh -----
// Assertion macros for the frame element local stiffness unit.
// Used by the RTL files that check their own logic; needs clk and arst_n in scope.
`ifndef FRAME_ELEMENT_LOCAL_STIFFNESS_UNIT_MACROS_SVH
`define FRAME_ELEMENT_LOCAL_STIFFNESS_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FELS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fels assertion failed");
`define FELS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fels assertion failed");
`else
`define FELS_ASSERT(lbl, prop)
`define FELS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/fels_pkg.sv -----
// Shared types, constants and functions of the frame element local stiffness unit.
// No dependencies.
`default_nettype none
package fels_pkg;

	localparam int ENTRY_COUNT = 26;
	localparam int DIV_STEPS = 80;

	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} fixval_t;

	typedef struct packed {
		logic signed [47:0] axial_term;
		logic signed [47:0] torsion_term;
		logic signed [47:0] bend_y_term;
		logic signed [47:0] bend_z_term;
		logic signed [31:0] fix_start_y;
		logic signed [31:0] fix_end_y;
		logic signed [31:0] fix_cross_y;
		logic signed [31:0] fix_axial;
		logic signed [31:0] fix_start_z;
		logic signed [31:0] fix_end_z;
		logic signed [31:0] fix_cross_z;
		logic [46:0]        element_length;
	} item_t;

	typedef struct packed {
		fixval_t            ael;
		fixval_t            gkl;
		fixval_t            eiy;
		fixval_t            eiy2;
		fixval_t            eiy3;
		fixval_t            eiz;
		fixval_t            eiz2;
		fixval_t            eiz3;
		logic signed [31:0] fsy;
		logic signed [31:0] fey;
		logic signed [31:0] fcy;
		logic signed [31:0] fax;
		logic signed [31:0] fsz;
		logic signed [31:0] fez;
		logic signed [31:0] fcz;
	} elem_t;

	typedef enum logic [1:0] {FR_IDLE, FR_DIV1, FR_DIV2, FR_PUSH} front_state_e;

	typedef enum logic [2:0] {
		TM_AEL, TM_GKL, TM_EIY, TM_EIY2, TM_EIY3, TM_EIZ, TM_EIZ2, TM_EIZ3
	} term_e;

	typedef enum logic [2:0] {FC_AX, FC_S, FC_E, FC_C, FC_1, FC_2, FC_3} fac_e;

	typedef struct packed {
		logic [3:0] row;
		logic [3:0] col;
		term_e      term;
		fac_e       fac;
		logic       neg;
	} entry_t;

	function automatic entry_t entry_lookup(input logic [4:0] k);
		entry_t e;
		e = '{4'd0, 4'd0, TM_AEL, FC_AX, 1'b0};
		unique case (k)
			5'd0:    e = '{4'd0, 4'd0, TM_AEL, FC_AX, 1'b0};
			5'd1:    e = '{4'd6, 4'd0, TM_AEL, FC_AX, 1'b1};
			5'd2:    e = '{4'd6, 4'd6, TM_AEL, FC_AX, 1'b0};
			5'd3:    e = '{4'd3, 4'd3, TM_GKL, FC_AX, 1'b0};
			5'd4:    e = '{4'd9, 4'd3, TM_GKL, FC_AX, 1'b1};
			5'd5:    e = '{4'd9, 4'd9, TM_GKL, FC_AX, 1'b0};
			5'd6:    e = '{4'd1, 4'd1, TM_EIZ3, FC_3, 1'b0};
			5'd7:    e = '{4'd5, 4'd1, TM_EIZ2, FC_1, 1'b0};
			5'd8:    e = '{4'd7, 4'd1, TM_EIZ3, FC_3, 1'b1};
			5'd9:    e = '{4'd11, 4'd1, TM_EIZ2, FC_2, 1'b0};
			5'd10:   e = '{4'd5, 4'd5, TM_EIZ, FC_S, 1'b0};
			5'd11:   e = '{4'd7, 4'd5, TM_EIZ2, FC_1, 1'b1};
			5'd12:   e = '{4'd11, 4'd5, TM_EIZ, FC_C, 1'b0};
			5'd13:   e = '{4'd7, 4'd7, TM_EIZ3, FC_3, 1'b0};
			5'd14:   e = '{4'd11, 4'd7, TM_EIZ2, FC_2, 1'b1};
			5'd15:   e = '{4'd11, 4'd11, TM_EIZ, FC_E, 1'b0};
			5'd16:   e = '{4'd2, 4'd2, TM_EIY3, FC_3, 1'b0};
			5'd17:   e = '{4'd4, 4'd2, TM_EIY2, FC_1, 1'b1};
			5'd18:   e = '{4'd8, 4'd2, TM_EIY3, FC_3, 1'b1};
			5'd19:   e = '{4'd10, 4'd2, TM_EIY2, FC_2, 1'b1};
			5'd20:   e = '{4'd4, 4'd4, TM_EIY, FC_S, 1'b0};
			5'd21:   e = '{4'd8, 4'd4, TM_EIY2, FC_1, 1'b0};
			5'd22:   e = '{4'd10, 4'd4, TM_EIY, FC_C, 1'b0};
			5'd23:   e = '{4'd8, 4'd8, TM_EIY3, FC_3, 1'b0};
			5'd24:   e = '{4'd10, 4'd8, TM_EIY2, FC_2, 1'b0};
			5'd25:   e = '{4'd10, 4'd10, TM_EIY, FC_E, 1'b0};
			default: e = '{4'd0, 4'd0, TM_AEL, FC_AX, 1'b0};
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/fels_queue.sv -----
// Two-entry queue of prepared elements between the front and the back.
// Depends on fels_pkg.
`default_nettype none
module fels_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  fels_pkg::elem_t     push_data,
	output logic                full,
	input  wire logic           pop,
	output logic                pop_valid,
	output fels_pkg::elem_t     pop_data
);
	import fels_pkg::*;

	elem_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/fels_front.sv -----
// Front end: accepts an element, forms the once and twice length-divided bending
// terms with two restoring dividers, and hands the element to the queue. Uses fels_pkg.
`default_nettype none
module fels_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  fels_pkg::item_t item,
	output logic            push,
	input  wire logic       q_full,
	output fels_pkg::elem_t elem
);
	import fels_pkg::*;

	localparam logic [6:0] LAST_STEP = 7'(DIV_STEPS - 1);

	front_state_e state_q, state_d;
	logic [6:0]   cnt_q;
	elem_t        elem_q;
	logic [46:0]  len_q;
	fixval_t      src_q [2];
	logic [79:0]  dd_q [2];
	logic [47:0]  rem_q [2];
	logic [79:0]  dd_n [2];
	logic [47:0]  rem_n [2];
	logic [47:0]  rsh [2];
	fixval_t      res [2];
	logic         len_zero;
	fixval_t      in_y, in_z;

	function automatic fixval_t from48(input logic [47:0] x);
		fixval_t r;
		logic [63:0] sx;
		sx = {{16{x[47]}}, x};
		r.neg = x[47];
		r.mag = x[47] ? (64'd0 - sx) : sx;
		return r;
	endfunction

	function automatic fixval_t sat_quot(input logic neg, input logic [79:0] q,
			input logic lz, input logic src_nz);
		fixval_t r;
		logic [63:0] lim;
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		if (lz) begin
			r.mag = src_nz ? lim : 64'd0;
		end else if (q[79:64] != 16'd0 || q[63:0] > lim) begin
			r.mag = lim;
		end else begin
			r.mag = q[63:0];
		end
		r.neg = neg && (r.mag != 64'd0);
		return r;
	endfunction

	assign in_stall = (state_q != FR_IDLE);
	assign push     = (state_q == FR_PUSH) && !q_full;
	assign elem     = elem_q;
	assign len_zero = (len_q == 47'd0);
	assign in_y     = from48(item.bend_y_term);
	assign in_z     = from48(item.bend_z_term);

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rsh[i] = {rem_q[i][46:0], dd_q[i][79]};
			if (rsh[i] >= {1'b0, len_q}) begin
				rem_n[i] = rsh[i] - {1'b0, len_q};
				dd_n[i]  = {dd_q[i][78:0], 1'b1};
			end else begin
				rem_n[i] = rsh[i];
				dd_n[i]  = {dd_q[i][78:0], 1'b0};
			end
			res[i] = sat_quot(src_q[i].neg, dd_n[i], len_zero, src_q[i].mag != 64'd0);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: begin
				if (in_valid) begin
					state_d = FR_DIV1;
				end
			end
			FR_DIV1: begin
				if (cnt_q == LAST_STEP) begin
					state_d = FR_DIV2;
				end
			end
			FR_DIV2: begin
				if (cnt_q == LAST_STEP) begin
					state_d = FR_PUSH;
				end
			end
			FR_PUSH: begin
				if (!q_full) begin
					state_d = FR_IDLE;
				end
			end
			default: state_d = FR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			cnt_q   <= 7'd0;
		end else begin
			state_q <= state_d;
			if ((state_q == FR_DIV1 || state_q == FR_DIV2) && cnt_q != LAST_STEP) begin
				cnt_q <= cnt_q + 7'd1;
			end else begin
				cnt_q <= 7'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FR_IDLE: begin
				if (in_valid) begin
					elem_q.ael <= from48(item.axial_term);
					elem_q.gkl <= from48(item.torsion_term);
					elem_q.eiy <= in_y;
					elem_q.eiz <= in_z;
					elem_q.fsy <= item.fix_start_y;
					elem_q.fey <= item.fix_end_y;
					elem_q.fcy <= item.fix_cross_y;
					elem_q.fax <= item.fix_axial;
					elem_q.fsz <= item.fix_start_z;
					elem_q.fez <= item.fix_end_z;
					elem_q.fcz <= item.fix_cross_z;
					len_q      <= item.element_length;
					src_q[0]   <= in_y;
					src_q[1]   <= in_z;
					dd_q[0]    <= {in_y.mag, 16'h0};
					dd_q[1]    <= {in_z.mag, 16'h0};
					rem_q[0]   <= 48'd0;
					rem_q[1]   <= 48'd0;
				end
			end
			FR_DIV1, FR_DIV2: begin
				if (cnt_q == LAST_STEP) begin
					if (state_q == FR_DIV1) begin
						elem_q.eiy2 <= res[0];
						elem_q.eiz2 <= res[1];
					end else begin
						elem_q.eiy3 <= res[0];
						elem_q.eiz3 <= res[1];
					end
					src_q[0] <= res[0];
					src_q[1] <= res[1];
					dd_q[0]  <= {res[0].mag, 16'h0};
					dd_q[1]  <= {res[1].mag, 16'h0};
					rem_q[0] <= 48'd0;
					rem_q[1] <= 48'd0;
				end else begin
					dd_q  <= dd_n;
					rem_q <= rem_n;
				end
			end
			FR_PUSH: begin
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/fels_back.sv -----
// Back end: walks the 26 entries of a queued element through a three-stage
// multiply, scale and saturate pipeline. Uses fels_pkg and the assertion macros.
`default_nettype none
`include "frame_element_local_stiffness_unit_macros.svh"
module fels_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	input  fels_pkg::elem_t   q_data,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [3:0]        row_index,
	output logic [3:0]        col_index,
	output logic signed [63:0] entry_value,
	output logic              last_entry
);
	import fels_pkg::*;

	localparam logic [4:0] LAST_K = 5'(ENTRY_COUNT - 1);

	logic        en, issue;
	logic [4:0]  k_q;
	entry_t      ent;
	fixval_t     tsel;
	logic signed [33:0] fs, fe, fc, f1, f2, fsel;
	logic [33:0] fmag;

	logic        v_s1, v_s2, v_s3;
	logic [63:0] tmag_s1;
	logic [33:0] fmag_s1;
	logic        neg_s1, neg_s2;
	logic [3:0]  row_s1, col_s1, row_s2, col_s2;
	logic        last_s1, last_s2;
	logic [65:0] pp_lo_s2, pp_hi_s2;
	logic [97:0] prod;
	logic [81:0] scaled;
	logic [63:0] lim, mag;

	assign en    = !v_s3 || !out_stall;
	assign issue = en && q_valid;
	assign pop   = issue && (k_q == LAST_K);
	assign ent   = entry_lookup(k_q);

	always_comb begin
		unique case (ent.term)
			TM_AEL:  tsel = q_data.ael;
			TM_GKL:  tsel = q_data.gkl;
			TM_EIY:  tsel = q_data.eiy;
			TM_EIY2: tsel = q_data.eiy2;
			TM_EIY3: tsel = q_data.eiy3;
			TM_EIZ:  tsel = q_data.eiz;
			TM_EIZ2: tsel = q_data.eiz2;
			TM_EIZ3: tsel = q_data.eiz3;
			default: tsel = q_data.ael;
		endcase
		if (ent.term == TM_EIZ || ent.term == TM_EIZ2 || ent.term == TM_EIZ3) begin
			fs = {{2{q_data.fsz[31]}}, q_data.fsz};
			fe = {{2{q_data.fez[31]}}, q_data.fez};
			fc = {{2{q_data.fcz[31]}}, q_data.fcz};
		end else begin
			fs = {{2{q_data.fsy[31]}}, q_data.fsy};
			fe = {{2{q_data.fey[31]}}, q_data.fey};
			fc = {{2{q_data.fcy[31]}}, q_data.fcy};
		end
		f1 = fs + fc;
		f2 = fe + fc;
		unique case (ent.fac)
			FC_AX:   fsel = {{2{q_data.fax[31]}}, q_data.fax};
			FC_S:    fsel = fs;
			FC_E:    fsel = fe;
			FC_C:    fsel = fc;
			FC_1:    fsel = f1;
			FC_2:    fsel = f2;
			FC_3:    fsel = f1 + f2;
			default: fsel = fs;
		endcase
		fmag = fsel[33] ? (34'd0 - fsel) : fsel;
	end

	always_comb begin
		prod   = {pp_hi_s2, 32'h0} + {32'h0, pp_lo_s2};
		scaled = prod[97:16];
		lim    = neg_s2 ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		if (scaled[81:64] != 18'd0 || scaled[63:0] > lim) begin
			mag = lim;
		end else begin
			mag = scaled[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= 5'd0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (issue) begin
				k_q <= (k_q == LAST_K) ? 5'd0 : k_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tmag_s1     <= tsel.mag;
			fmag_s1     <= fmag;
			neg_s1      <= tsel.neg ^ fsel[33] ^ ent.neg;
			row_s1      <= ent.row;
			col_s1      <= ent.col;
			last_s1     <= (k_q == LAST_K);
			pp_lo_s2    <= tmag_s1[31:0] * fmag_s1;
			pp_hi_s2    <= tmag_s1[63:32] * fmag_s1;
			neg_s2      <= neg_s1;
			row_s2      <= row_s1;
			col_s2      <= col_s1;
			last_s2     <= last_s1;
			entry_value <= neg_s2 ? (64'd0 - mag) : mag;
			row_index   <= row_s2;
			col_index   <= col_s2;
			last_entry  <= last_s2;
		end
	end

	assign out_valid = v_s3;

	`FELS_ASSERT(a_k_range, k_q <= LAST_K)
	`FELS_ASSERT(a_last_pos, (v_s3 && last_entry) |-> (row_index == 4'd10 && col_index == 4'd10))
	`FELS_ASSERT(a_pop_valid, pop |-> q_valid)
	`FELS_ASSERT_NEXT(a_pop_wrap, pop, k_q == 5'd0)
endmodule
`default_nettype wire

// ----- rtl/frame_element_local_stiffness_unit.sv -----
// Top level of the frame element local stiffness unit: front divider stage,
// element queue and entry pipeline. Uses fels_pkg, fels_front, fels_queue, fels_back.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  section terms, fixity factors, element_length
//   out      out_valid/out_stall  row_index, col_index, entry_value, last_entry
//
// The front takes one element at a time, stalling its input until it is pushed; two
// restoring dividers run 80 steps for the once- and 80 for the twice-divided terms.
// The back emits 26 entries per element, one per cycle unless stalled or queue-empty.
// A two-entry queue lets the front divide the next element while entries drain.
// Reset clears the control state only; a stall of a valid output freezes the back pipeline.
`default_nettype none
module frame_element_local_stiffness_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [47:0] axial_term,
	input  wire logic signed [47:0] torsion_term,
	input  wire logic signed [47:0] bend_y_term,
	input  wire logic signed [47:0] bend_z_term,
	input  wire logic signed [31:0] fix_start_y,
	input  wire logic signed [31:0] fix_end_y,
	input  wire logic signed [31:0] fix_cross_y,
	input  wire logic signed [31:0] fix_axial,
	input  wire logic signed [31:0] fix_start_z,
	input  wire logic signed [31:0] fix_end_z,
	input  wire logic signed [31:0] fix_cross_z,
	input  wire logic [46:0]        element_length,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [3:0]              row_index,
	output logic [3:0]              col_index,
	output logic signed [63:0]      entry_value,
	output logic                    last_entry
);
	import fels_pkg::*;

	item_t item;
	elem_t push_data, pop_data;
	logic  push, q_full, pop, q_valid;

	assign item = '{axial_term, torsion_term, bend_y_term, bend_z_term,
		fix_start_y, fix_end_y, fix_cross_y, fix_axial,
		fix_start_z, fix_end_z, fix_cross_z, element_length};

	fels_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.push     (push),
		.q_full   (q_full),
		.elem     (push_data)
	);

	fels_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_data  (pop_data)
	);

	fels_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row_index   (row_index),
		.col_index   (col_index),
		.entry_value (entry_value),
		.last_entry  (last_entry)
	);
endmodule
`default_nettype wire

// ----- bench/frame_element_local_stiffness_unit_tb.sv -----
// Self-checking testbench for the frame element local stiffness unit.
// Drives element requests, predicts the 26 matrix entries of each in a scoreboard class.
// Depends on fels_pkg and frame_element_local_stiffness_unit.
`default_nettype none
module frame_element_local_stiffness_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fels_pkg::*;

	localparam logic [63:0] POS_LIM = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;
	localparam int N_RANDOM = 287;
	localparam int N_QUIET = 50;

	typedef struct {
		logic [3:0]  row;
		logic [3:0]  col;
		logic [63:0] value;
		logic        last;
	} stiff_entry_t;

	class stiffness_scoreboard;
		stiff_entry_t pending_entries[$];
		int mismatches;
		term_e ent_term[ENTRY_COUNT];
		fac_e ent_fac[ENTRY_COUNT];
		bit ent_neg[ENTRY_COUNT];
		logic [3:0] ent_row[ENTRY_COUNT];
		logic [3:0] ent_col[ENTRY_COUNT];

		function new();
			ent_row = '{0, 6, 6, 3, 9, 9, 1, 5, 7, 11, 5, 7, 11, 7, 11, 11,
				2, 4, 8, 10, 4, 8, 10, 8, 10, 10};
			ent_col = '{0, 0, 6, 3, 3, 9, 1, 1, 1, 1, 5, 5, 5, 7, 7, 11,
				2, 2, 2, 2, 4, 4, 4, 8, 8, 10};
			ent_term = '{TM_AEL, TM_AEL, TM_AEL, TM_GKL, TM_GKL, TM_GKL,
				TM_EIZ3, TM_EIZ2, TM_EIZ3, TM_EIZ2, TM_EIZ, TM_EIZ2, TM_EIZ, TM_EIZ3,
				TM_EIZ2, TM_EIZ,
				TM_EIY3, TM_EIY2, TM_EIY3, TM_EIY2, TM_EIY, TM_EIY2, TM_EIY, TM_EIY3,
				TM_EIY2, TM_EIY};
			ent_fac = '{FC_AX, FC_AX, FC_AX, FC_AX, FC_AX, FC_AX,
				FC_3, FC_1, FC_3, FC_2, FC_S, FC_1, FC_C, FC_3, FC_2, FC_E,
				FC_3, FC_1, FC_3, FC_2, FC_S, FC_1, FC_C, FC_3, FC_2, FC_E};
			ent_neg = '{0, 1, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 0, 0, 1, 0,
				0, 1, 1, 1, 0, 0, 0, 0, 0, 0};
			mismatches = 0;
		endfunction

		function logic [63:0] saturate(bit n, logic [127:0] v);
			logic [63:0] lim;
			lim = n ? NEG_LIM : POS_LIM;
			return (v > {64'd0, lim}) ? lim : v[63:0];
		endfunction

		function logic [63:0] magnitude(longint v);
			return (v < 0) ? 64'(-v) : 64'(v);
		endfunction

		function void divide_by_length(input bit n, input logic [63:0] m, input logic [46:0] len,
				output bit qn, output logic [63:0] qm);
			logic [127:0] q;
			if (len == 0) begin
				qm = (m != 0) ? (n ? NEG_LIM : POS_LIM) : 64'd0;
			end else begin
				q = ({64'd0, m} << 16) / {81'd0, len};
				qm = saturate(n, q);
			end
			qn = n && (qm != 0);
		endfunction

		function logic [63:0] scaled_entry(bit an, logic [63:0] am, bit bn, logic [63:0] bm,
				bit negate);
			logic [127:0] p;
			logic [63:0] m;
			bit n;
			p = {64'd0, am} * {64'd0, bm};
			n = an ^ bn ^ negate;
			m = saturate(n, p >> 16);
			if (m == 0)
				return 64'd0;
			return n ? -m : m;
		endfunction

		function void note_element(item_t it);
			bit tn[8];
			logic [63:0] tm[8];
			bit fn;
			logic [63:0] fm;
			longint s, e, c, f;
			stiff_entry_t x;
			term_e t;
			tn[TM_AEL] = it.axial_term < 0;
			tm[TM_AEL] = magnitude(longint'(it.axial_term));
			tn[TM_GKL] = it.torsion_term < 0;
			tm[TM_GKL] = magnitude(longint'(it.torsion_term));
			tn[TM_EIY] = it.bend_y_term < 0;
			tm[TM_EIY] = magnitude(longint'(it.bend_y_term));
			tn[TM_EIZ] = it.bend_z_term < 0;
			tm[TM_EIZ] = magnitude(longint'(it.bend_z_term));
			divide_by_length(tn[TM_EIY], tm[TM_EIY], it.element_length, tn[TM_EIY2], tm[TM_EIY2]);
			divide_by_length(tn[TM_EIY2], tm[TM_EIY2], it.element_length, tn[TM_EIY3],
				tm[TM_EIY3]);
			divide_by_length(tn[TM_EIZ], tm[TM_EIZ], it.element_length, tn[TM_EIZ2], tm[TM_EIZ2]);
			divide_by_length(tn[TM_EIZ2], tm[TM_EIZ2], it.element_length, tn[TM_EIZ3],
				tm[TM_EIZ3]);
			for (int k = 0; k < ENTRY_COUNT; k++) begin
				t = ent_term[k];
				if (t == TM_EIY || t == TM_EIY2 || t == TM_EIY3) begin
					s = it.fix_start_y;
					e = it.fix_end_y;
					c = it.fix_cross_y;
				end else begin
					s = it.fix_start_z;
					e = it.fix_end_z;
					c = it.fix_cross_z;
				end
				case (ent_fac[k])
					FC_AX: f = it.fix_axial;
					FC_S: f = s;
					FC_E: f = e;
					FC_C: f = c;
					FC_1: f = s + c;
					FC_2: f = e + c;
					default: f = s + c + e + c;
				endcase
				fn = f < 0;
				fm = magnitude(f);
				x.row = ent_row[k];
				x.col = ent_col[k];
				x.value = scaled_entry(tn[t], tm[t], fn, fm, ent_neg[k]);
				x.last = (k == ENTRY_COUNT - 1);
				pending_entries.push_back(x);
			end
		endfunction

		function void check_entry(logic [3:0] row, logic [3:0] col, logic [63:0] value,
				logic last);
			stiff_entry_t x;
			if (pending_entries.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected entry row %0d col %0d value %h", row, col, value);
				return;
			end
			x = pending_entries.pop_front();
			if (row !== x.row || col !== x.col || value !== x.value || last !== x.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("entry mismatch: expected %0d,%0d %h last %b, got %0d,%0d %h last %b",
						x.row, x.col, x.value, x.last, row, col, value, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	item_t req;
	logic out_valid;
	logic out_stall;
	logic [3:0] row_index;
	logic [3:0] col_index;
	logic signed [63:0] entry_value;
	logic last_entry;
	bit quiet;
	int stall_left;
	stiffness_scoreboard sb;

	frame_element_local_stiffness_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.axial_term(req.axial_term),
		.torsion_term(req.torsion_term),
		.bend_y_term(req.bend_y_term),
		.bend_z_term(req.bend_z_term),
		.fix_start_y(req.fix_start_y),
		.fix_end_y(req.fix_end_y),
		.fix_cross_y(req.fix_cross_y),
		.fix_axial(req.fix_axial),
		.fix_start_z(req.fix_start_z),
		.fix_end_z(req.fix_end_z),
		.fix_cross_z(req.fix_cross_z),
		.element_length(req.element_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.row_index(row_index),
		.col_index(col_index),
		.entry_value(entry_value),
		.last_entry(last_entry)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("[frame_element_local_stiffness_unit] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_element(req);
		if (arst_n && out_valid && !out_stall)
			sb.check_entry(row_index, col_index, entry_value, last_entry);
	end

	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [47:0] random_term();
		case ($urandom_range(0, 6))
			0: return 48'h7fff_ffff_ffff;
			1: return 48'h8000_0000_0000;
			2: return 48'(longint'($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return 48'({$urandom, $urandom} >> 16);
			4: return 48'(longint'($urandom_range(0, 32'h7fff_ffff)) * ($urandom_range(0, 1) ? 1 : -1));
			5: return 48'(longint'($urandom_range(1, 200)) << 16);
			default: return 48'd0;
		endcase
	endfunction

	function automatic logic [31:0] random_factor();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom;
			3: return 32'($urandom_range(0, 8) << 14) * ($urandom_range(0, 1) ? 1 : -1);
			default: return 32'h0001_0000;
		endcase
	endfunction

	function automatic logic [46:0] random_length();
		case ($urandom_range(0, 9))
			0: return 47'd0;
			1: return 47'd1;
			2: return 47'h7fff_ffff_ffff;
			3: return 47'({$urandom, $urandom} >> 17);
			4: return 47'($urandom_range(1, 1 << 20));
			default: return 47'(longint'($urandom_range(1, 40)) << 16);
		endcase
	endfunction

	function automatic item_t random_element();
		item_t it;
		it.axial_term = random_term();
		it.torsion_term = random_term();
		it.bend_y_term = random_term();
		it.bend_z_term = random_term();
		it.fix_start_y = random_factor();
		it.fix_end_y = random_factor();
		it.fix_cross_y = random_factor();
		it.fix_axial = random_factor();
		it.fix_start_z = random_factor();
		it.fix_end_z = random_factor();
		it.fix_cross_z = random_factor();
		it.element_length = random_length();
		return it;
	endfunction

	task automatic send_element(item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_uniform(logic [47:0] t, logic [31:0] f, logic [46:0] len);
		item_t it;
		it = '{t, t, t, t, f, f, f, f, f, f, f, len};
		send_element(it);
	endtask

	initial begin
		item_t it;
		int wait_cycles;
		sb = new();
		quiet = 1'b0;
		stall_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_uniform(48'd0, 32'd0, 47'd1);
		send_uniform(48'h0001_0000, 32'h0001_0000, 47'h0001_0000);
		send_uniform(48'h7fff_ffff_ffff, 32'h7fff_ffff, 47'd1);
		send_uniform(48'h8000_0000_0000, 32'h8000_0000, 47'd1);
		send_uniform(48'h7fff_ffff_ffff, 32'h8000_0000, 47'h7fff_ffff_ffff);
		send_uniform(48'h8000_0000_0000, 32'h7fff_ffff, 47'h7fff_ffff_ffff);
		send_uniform(48'h0005_0000, 32'h0001_0000, 47'd0);
		send_uniform(48'hffff_fffb_0000, 32'hffff_0000, 47'd0);
		send_uniform(48'd0, 32'h0001_0000, 47'd0);
		send_uniform(48'hffff_ffff_ffff, 32'hffff_ffff, 47'h0002_0000);
		send_uniform(48'h0000_0003_0000, 32'h0000_8000, 47'h0000_4000);
		it = '{48'h0010_0000, -48'sh0020_0000, 48'h0003_0000, -48'sh0004_0000,
			32'h0004_0000, 32'h0002_0000, -32'sh0001_0000, 32'h0001_0000,
			-32'sh0003_0000, 32'h0005_0000, 32'h0000_8000, 47'h0003_0000};
		send_element(it);
		it.element_length = 47'h5555_5555_5555;
		it.fix_cross_y = 32'h8000_0000;
		send_element(it);

		for (int n = 0; n < N_RANDOM + N_QUIET; n++) begin
			if (n == N_RANDOM)
				quiet = 1'b1;
			send_element(random_element());
		end
		in_valid <= 1'b0;

		wait_cycles = 0;
		while (sb.pending_entries.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_entries.size() == 0)
			$display("[frame_element_local_stiffness_unit] OK");
		else
			$display("[frame_element_local_stiffness_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
